/* hdl/cecp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cecp_pkg
// Types, constants and CRC helpers for the CAN end-to-end frame protector.
// ----------------------------------------------------------------------------
package cecp_pkg;

  localparam logic [7:0] CrcPoly    = 8'h2F;
  localparam logic [7:0] CrcInit    = 8'hFF;
  localparam logic [7:0] CrcXorOut  = 8'hFF;
  localparam logic [7:0] NibHiMask  = 8'hF0;

  localparam logic [10:0] IdX040 = 11'h040;
  localparam logic [10:0] IdX116 = 11'h116;
  localparam logic [10:0] IdX31E = 11'h31E;
  localparam logic [10:0] IdX32A = 11'h32A;
  localparam logic [10:0] IdX394 = 11'h394;
  localparam logic [10:0] IdX3C0 = 11'h3C0;
  localparam logic [10:0] IdX641 = 11'h641;

  localparam logic [7:0] KonstX040 = 8'h40;
  localparam logic [7:0] KonstX116 = 8'hAC;
  localparam logic [7:0] KonstX32A = 8'h29;
  localparam logic [7:0] KonstX3C0 = 8'hC3;
  localparam logic [7:0] KonstX641 = 8'h47;

  typedef struct packed {
    logic [10:0] frame_id;
    logic [7:0]  data_byte;
    logic [3:0]  seq_counter;
    logic        last_byte;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
    logic       overflow;
  } out_beat_t;

  // what the checksum unit needs from a finished frame
  typedef struct packed {
    logic [7:0]  crc;
    logic [10:0] frame_id;
    logic [3:0]  seq_counter;
  } chk_src_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] konst;
  } id_konst_t;

  function automatic logic [7:0] crc8_fold(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ CrcPoly) : (c << 1);
    end
    return c;
  endfunction

  function automatic logic [7:0] konst_394(input logic [3:0] cnt);
    logic [7:0] r;
    case (cnt)
      4'd0:  r = 8'h47;
      4'd1:  r = 8'h94;
      4'd2:  r = 8'h92;
      4'd3:  r = 8'h6A;
      4'd4:  r = 8'h67;
      4'd5:  r = 8'hB5;
      4'd6:  r = 8'h0D;
      4'd7:  r = 8'h38;
      4'd8:  r = 8'hE3;
      4'd9:  r = 8'h8A;
      4'd10: r = 8'h5D;
      4'd11: r = 8'hB4;
      4'd12: r = 8'h54;
      4'd13: r = 8'hAB;
      4'd14: r = 8'hAE;
      default: r = 8'h27;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] konst_31e(input logic [3:0] cnt);
    logic [7:0] r;
    case (cnt)
      4'd0:  r = 8'h78;
      4'd1:  r = 8'h68;
      4'd2:  r = 8'h3A;
      4'd3:  r = 8'h31;
      4'd4:  r = 8'h16;
      4'd5:  r = 8'h08;
      4'd6:  r = 8'h4F;
      4'd7:  r = 8'hDE;
      4'd8:  r = 8'hF7;
      4'd9:  r = 8'h35;
      4'd10: r = 8'h19;
      4'd11: r = 8'hE6;
      4'd12: r = 8'h28;
      4'd13: r = 8'h2F;
      4'd14: r = 8'h59;
      default: r = 8'h82;
    endcase
    return r;
  endfunction

  function automatic id_konst_t id_konst(input logic [10:0] id, input logic [3:0] cnt);
    id_konst_t r;
    r.hit   = 1'b1;
    r.konst = '0;
    unique case (id)
      IdX040: r.konst = KonstX040;
      IdX116: r.konst = KonstX116;
      IdX31E: r.konst = konst_31e(cnt);
      IdX32A: r.konst = KonstX32A;
      IdX394: r.konst = konst_394(cnt);
      IdX3C0: r.konst = KonstX3C0;
      IdX641: r.konst = KonstX641;
      default: r.hit  = 1'b0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

/* hdl/cecp_checksum.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cecp_checksum
// Folds the per-identifier data constant, for identifiers in the table, into
// a frame's running CRC and applies the final inversion.
// ----------------------------------------------------------------------------
module cecp_checksum (
  input  var cecp_pkg::chk_src_t src_i,
  output logic [7:0]            checksum_o
);

  cecp_pkg::id_konst_t ik;
  logic [7:0]          crc_k;

  always_comb begin
    ik    = cecp_pkg::id_konst(src_i.frame_id, src_i.seq_counter);
    crc_k = ik.hit ? cecp_pkg::crc8_fold(src_i.crc, ik.konst) : src_i.crc;
  end

  assign checksum_o = crc_k ^ cecp_pkg::CrcXorOut;

endmodule
`default_nettype wire

/* hdl/can_e2e_crc8_counter_protect.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// can_e2e_crc8_counter_protect
// Buffers a CAN payload byte by byte, inserts the alive counter, computes
// the CRC8 checksum, emits the protected frame (byte 0 replaced if >1 byte).
// ----------------------------------------------------------------------------
// throughput: one input beat and one output beat per cycle unless stalled;
//   the frame buffer holds two banks, so a frame fills while the previous
//   one drains, and a final beat waits until the previous frame's last
//   byte is read; the final beat registers the frame descriptor, then each
//   byte passes the read register and the output register in turn
// reset: asynchronous, clears control state; buffer and data regs not reset
module can_e2e_crc8_counter_protect #(
  parameter int unsigned MAX_BYTES = 8
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_stall_o,
  input  var cecp_pkg::in_beat_t in_data_i,
  output logic                  out_valid_o,
  input  wire                   out_stall_i,
  output cecp_pkg::out_beat_t   out_data_o
);

  localparam int unsigned AW    = $clog2(MAX_BYTES);
  localparam int unsigned PW    = $clog2(MAX_BYTES + 1);
  localparam int unsigned Depth = 2 ** (AW + 1);

  localparam logic [PW-1:0] MaxPos = PW'(MAX_BYTES);
  localparam logic [PW-1:0] OnePos = PW'(1);
  localparam logic [PW-1:0] TwoPos = PW'(2);

  // ---------------- write side ----------------
  logic [PW-1:0] pos_q, pos_d;
  logic [7:0]    crc_q, crc_d;
  logic [10:0]   id_q, id_d;
  logic [3:0]    cnt_q, cnt_d;
  logic          ovf_q, ovf_d;
  logic          wbank_q;

  logic          in_acc, pos_full, mem_we;
  logic [7:0]    byte_w;
  logic [AW:0]   waddr;

  // pending frame descriptor
  logic               desc_v_q;
  logic               desc_bank_q;
  logic [PW-1:0]      desc_n_q;
  logic               desc_ovf_q;
  cecp_pkg::chk_src_t desc_src_q;
  cecp_pkg::chk_src_t src_d;

  assign in_acc     = in_valid_i && !in_stall_o;
  assign pos_full   = (pos_q == MaxPos);
  assign mem_we     = in_acc && !pos_full;
  assign waddr      = {wbank_q, pos_q[AW-1:0]};

  always_comb begin
    byte_w = in_data_i.data_byte;
    if (pos_q == OnePos) begin
      byte_w = (in_data_i.data_byte & cecp_pkg::NibHiMask) | {4'b0000, cnt_q};
    end
    id_d  = (pos_q == '0) ? in_data_i.frame_id : id_q;
    cnt_d = (pos_q == '0) ? in_data_i.seq_counter : cnt_q;
    crc_d = (pos_q != '0 && !pos_full) ? cecp_pkg::crc8_fold(crc_q, byte_w) : crc_q;
    pos_d = pos_full ? pos_q : pos_q + OnePos;
    ovf_d = ovf_q | pos_full;
    src_d.crc         = crc_d;
    src_d.frame_id    = id_d;
    src_d.seq_counter = cnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      crc_q   <= cecp_pkg::CrcInit;
      id_q    <= '0;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
      wbank_q <= 1'b0;
    end else if (in_acc) begin
      if (in_data_i.last_byte) begin
        pos_q   <= '0;
        crc_q   <= cecp_pkg::CrcInit;
        id_q    <= '0;
        cnt_q   <= '0;
        ovf_q   <= 1'b0;
        wbank_q <= !wbank_q;
      end else begin
        pos_q <= pos_d;
        crc_q <= crc_d;
        id_q  <= id_d;
        cnt_q <= cnt_d;
        ovf_q <= ovf_d;
      end
    end
  end

  // ---------------- read side ----------------
  logic [AW-1:0] rd_idx_q;
  logic [AW:0]   raddr;
  logic          out_ld, s1_adv, issue, rd_last;
  logic [7:0]    checksum;
  logic [7:0]    rd_data_q;
  logic          s1_v_q;
  logic          s1_sub_v_q;
  logic [7:0]    s1_sub_q;
  logic          s1_end_q;
  logic          s1_ovf_q;
  logic          out_valid_q;
  cecp_pkg::out_beat_t out_data_q;

  logic [7:0] mem [Depth];

  cecp_checksum u_checksum (
    .src_i      (desc_src_q),
    .checksum_o (checksum)
  );

  assign out_ld  = !out_valid_q || !out_stall_i;
  assign s1_adv  = s1_v_q && out_ld;
  assign issue   = desc_v_q && (!s1_v_q || s1_adv);
  assign rd_last = ((PW'(rd_idx_q) + OnePos) == desc_n_q);
  assign raddr   = {desc_bank_q, rd_idx_q};

  // a final beat may enter as the pending frame's last byte is read
  assign in_stall_o = desc_v_q && !(issue && rd_last) && in_data_i.last_byte;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= byte_w;
    end
    if (issue) begin
      rd_data_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      desc_v_q <= 1'b0;
      rd_idx_q <= '0;
      s1_v_q   <= 1'b0;
    end else begin
      if (in_acc && in_data_i.last_byte) begin
        desc_v_q <= 1'b1;
      end else if (issue && rd_last) begin
        desc_v_q <= 1'b0;
      end
      if (issue) begin
        rd_idx_q <= rd_last ? '0 : rd_idx_q + AW'(1);
        s1_v_q   <= 1'b1;
      end else if (s1_adv) begin
        s1_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && in_data_i.last_byte) begin
      desc_bank_q <= wbank_q;
      desc_n_q    <= pos_d;
      desc_ovf_q  <= ovf_d;
      desc_src_q  <= src_d;
    end
    if (issue) begin
      // byte 0 carries the checksum once the frame has at least two bytes
      s1_sub_v_q <= (rd_idx_q == '0) && (desc_n_q >= TwoPos);
      s1_sub_q   <= checksum;
      s1_end_q   <= rd_last;
      s1_ovf_q   <= desc_ovf_q;
    end
    if (out_ld && s1_v_q) begin
      out_data_q.out_byte  <= s1_sub_v_q ? s1_sub_q : rd_data_q;
      out_data_q.frame_end <= s1_end_q;
      out_data_q.overflow  <= s1_ovf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ld) begin
      out_valid_q <= s1_v_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // the bank being drained is never overwritten
  a_bank_split: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && desc_v_q) |-> (waddr[AW] != desc_bank_q))
    else $error("write hit the bank being read");

  a_rd_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    desc_v_q |-> (PW'(rd_idx_q) < desc_n_q))
    else $error("read index beyond frame length");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= MaxPos)
    else $error("byte position beyond buffer");

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && !out_ld) |=> $stable(rd_data_q))
    else $error("read data lost while output stalled");

endmodule
`default_nettype wire
